@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, also during reset
`define ASSERT_CLK(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

// property checked outside reset
`define ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

`endif

@@ rtl/ibf_pkg.sv @@
`default_nettype none

package ibf_pkg;

   localparam int HASH_BITS     = 32;
   localparam int LEVEL_BITS    = 8;
   localparam int COUNT_BITS    = 8;
   localparam int WORD_BITS     = 8;
   localparam int BIT_SEL_BITS  = 3;
   localparam int MAC_BITS      = HASH_BITS + COUNT_BITS + 1;
   localparam int REQ_DATA_BITS = HASH_BITS + LEVEL_BITS;
   localparam int RSP_DATA_BITS = 8;

   localparam logic [COUNT_BITS-1:0] COUNT_RESET = 8'd1;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_QUERY  = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    last_probe;
   } probe_ctl_type;

endpackage

`default_nettype wire

@@ rtl/ibf_index.sv @@
`default_nettype none

// Bit position: hash * filter_count + level, low bits kept.
module ibf_index #(
   parameter int POS_BITS = 20
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               advance,
   input  wire                               accept,
   input  wire  [ibf_pkg::HASH_BITS-1:0]     hash_value,
   input  wire  [ibf_pkg::LEVEL_BITS-1:0]    filter_level,
   input  wire  [ibf_pkg::COUNT_BITS-1:0]    filter_count,
   input  wire  ibf_pkg::probe_ctl_type      ctl,
   output logic                              valid,
   output logic [POS_BITS-1:0]               pos,
   output ibf_pkg::probe_ctl_type            ctl_out
);
   import ibf_pkg::*;

   logic                valid_ff;
   logic [POS_BITS-1:0] pos_ff;
   probe_ctl_type       ctl_ff;
   logic [MAC_BITS-1:0] mac_in;

   assign mac_in = MAC_BITS'(hash_value) * MAC_BITS'(filter_count)
                 + MAC_BITS'(filter_level);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && accept) begin
         pos_ff <= mac_in[POS_BITS-1:0];
         ctl_ff <= ctl;
      end
   end

   assign valid   = valid_ff;
   assign pos     = pos_ff;
   assign ctl_out = ctl_ff;

endmodule

`default_nettype wire

@@ rtl/ibf_store.sv @@
`default_nettype none

`include "assert_macros.svh"

// Bit store: one read port, one write port, read data in the next cycle.
// A write to the word being read in the same cycle is forwarded.
// After reset the whole store is swept to zero, one word a cycle.
module ibf_store #(
   parameter int ADDR_BITS = 17
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                rd_en,
   input  wire  [ADDR_BITS-1:0]               rd_addr,
   input  wire                                wr_en,
   input  wire  [ADDR_BITS-1:0]               wr_addr,
   input  wire  [ibf_pkg::WORD_BITS-1:0]      wr_data,
   output logic [ibf_pkg::WORD_BITS-1:0]      rd_data,
   output logic                               clear_busy
);
   import ibf_pkg::*;

   localparam int WORDS = 1 << ADDR_BITS;

   logic [WORD_BITS-1:0] mem_ff [0:WORDS-1];
   logic [WORD_BITS-1:0] q_ff;
   logic                 fwd_ff;
   logic [WORD_BITS-1:0] fwd_data_ff;
   logic                 clear_ff;
   logic [ADDR_BITS-1:0] clear_addr_ff;
   logic                 clear_in;
   logic [ADDR_BITS-1:0] clear_addr_in;
   logic                 mem_we;
   logic [ADDR_BITS-1:0] mem_waddr;
   logic [WORD_BITS-1:0] mem_wdata;

   always_comb begin
      clear_in      = clear_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_ff) begin
         clear_addr_in = clear_addr_ff + ADDR_BITS'(1);
         if (clear_addr_ff == {ADDR_BITS{1'b1}}) begin
            clear_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
      end else begin
         clear_ff      <= clear_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   assign mem_we    = clear_ff || wr_en;
   assign mem_waddr = clear_ff ? clear_addr_ff : wr_addr;
   assign mem_wdata = clear_ff ? '0 : wr_data;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         q_ff        <= mem_ff[rd_addr];
         fwd_ff      <= wr_en && (wr_addr == rd_addr);
         fwd_data_ff <= wr_data;
      end
   end

   assign rd_data    = fwd_ff ? fwd_data_ff : q_ff;
   assign clear_busy = clear_ff;

   `ASSERT_CLK(a_clear_after_reset, clock, reset |=> clear_ff)
   `ASSERT_RST(a_no_write_in_clear, clock, reset, clear_ff |-> !(wr_en || rd_en))

endmodule

`default_nettype wire

@@ rtl/interleaved_bloom_filter.sv @@
`default_nettype none

`include "assert_macros.svh"

// Interleaved Bloom filter bit store. Each req item is one probe (tuser: 0
// insert, 1 query; tlast marks the last probe of a key); a rsp item carrying
// key_present comes out for every last probe only. Probes flow through a
// two-stage pipeline (bit position, then read-modify-write of one store word)
// at one probe per cycle while not held, with same-word writes forwarded so
// back-to-back probes need no gaps; a last probe's result is registered onto
// rsp after both stages. The pipeline holds only while a result waits on rsp
// and the next last probe is ready to leave. After reset the store is cleared
// one word per cycle: req_tready stays low until all 2^(STORE_ADDR_BITS-3)
// words are cleared, csr writes are taken throughout. filter_count is written
// by csr_wr_en and takes effect on probes accepted from the next cycle.
module interleaved_bloom_filter #(
   parameter int STORE_ADDR_BITS = 20
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   csr_wr_en,
   input  wire  [ibf_pkg::COUNT_BITS-1:0]        csr_wr_data,    // filter_count
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   input  wire  [ibf_pkg::REQ_DATA_BITS-1:0]     req_tdata,      // hash_value, filter_level
   input  wire                                   req_tuser,      // cmd
   input  wire                                   req_tlast,      // last_probe
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   output logic [ibf_pkg::RSP_DATA_BITS-1:0]     rsp_tdata       // key_present, zero fill
);
   import ibf_pkg::*;

   localparam int WADDR_BITS = STORE_ADDR_BITS - BIT_SEL_BITS;

   logic [COUNT_BITS-1:0]   count_ff;
   logic                    advance;
   logic                    accept;
   logic                    clear_busy;
   probe_ctl_type           req_ctl;

   logic                    s1_valid;
   logic [STORE_ADDR_BITS-1:0] s1_pos;
   probe_ctl_type           s1_ctl;

   logic                    s2_valid_ff;
   probe_ctl_type           s2_ctl_ff;
   logic [WADDR_BITS-1:0]   s2_waddr_ff;
   logic [BIT_SEL_BITS-1:0] s2_bit_ff;

   logic [WORD_BITS-1:0]    rd_word;
   logic [WORD_BITS-1:0]    wr_word;
   logic                    wr_en;
   logic                    bit_hit;
   logic                    hit_acc;
   logic                    present;

   logic                    all_hit_ff;
   logic                    all_hit_in;
   logic                    rsp_valid_ff;
   logic                    rsp_present_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   // hold only when a result must leave and the output slot is still taken
   assign advance    = !(s2_valid_ff && s2_ctl_ff.last_probe && rsp_valid_ff && !rsp_tready);
   assign req_tready = advance && !clear_busy;
   assign accept     = req_tvalid && req_tready;

   assign req_ctl = '{cmd: cmd_type'(req_tuser), last_probe: req_tlast};

   ibf_index #(
      .POS_BITS (STORE_ADDR_BITS)
   ) u_index (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .accept       (accept),
      .hash_value   (req_tdata[HASH_BITS-1:0]),
      .filter_level (req_tdata[REQ_DATA_BITS-1:HASH_BITS]),
      .filter_count (count_ff),
      .ctl          (req_ctl),
      .valid        (s1_valid),
      .pos          (s1_pos),
      .ctl_out      (s1_ctl)
   );

   ibf_store #(
      .ADDR_BITS (WADDR_BITS)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (advance && s1_valid),
      .rd_addr    (s1_pos[STORE_ADDR_BITS-1:BIT_SEL_BITS]),
      .wr_en      (wr_en),
      .wr_addr    (s2_waddr_ff),
      .wr_data    (wr_word),
      .rd_data    (rd_word),
      .clear_busy (clear_busy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid) begin
         s2_ctl_ff   <= s1_ctl;
         s2_waddr_ff <= s1_pos[STORE_ADDR_BITS-1:BIT_SEL_BITS];
         s2_bit_ff   <= s1_pos[BIT_SEL_BITS-1:0];
      end
   end

   assign bit_hit = rd_word[s2_bit_ff];
   assign hit_acc = all_hit_ff && bit_hit;
   assign present = (s2_ctl_ff.cmd == CMD_QUERY) && hit_acc;
   assign wr_word = rd_word | (WORD_BITS'(1) << s2_bit_ff);
   assign wr_en   = advance && s2_valid_ff && (s2_ctl_ff.cmd == CMD_INSERT);

   always_comb begin
      all_hit_in = all_hit_ff;
      if (advance && s2_valid_ff) begin
         if (s2_ctl_ff.last_probe) begin
            all_hit_in = 1'b1;
         end else if (s2_ctl_ff.cmd == CMD_QUERY) begin
            all_hit_in = hit_acc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         all_hit_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         all_hit_ff <= all_hit_in;
         if (advance && s2_valid_ff && s2_ctl_ff.last_probe) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s2_valid_ff && s2_ctl_ff.last_probe) begin
         rsp_present_ff <= present;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(rsp_present_ff);

   `ASSERT_RST(a_empty_in_clear, clock, reset,
      clear_busy |-> !(s1_valid || s2_valid_ff))
   `ASSERT_RST(a_rsp_from_last, clock, reset,
      $rose(rsp_valid_ff) |-> $past(s2_valid_ff && s2_ctl_ff.last_probe))
   `ASSERT_RST(a_insert_absent, clock, reset,
      (advance && s2_valid_ff && s2_ctl_ff.last_probe && s2_ctl_ff.cmd == CMD_INSERT)
      |=> (rsp_valid_ff && !rsp_present_ff))

endmodule

`default_nettype wire
